FILE: rtl/prime_count_sieve_assert.svh
// ---------------------------------------------------------------------------
// prime_count_sieve assertion macros
// shared property forms used by the checker
// ---------------------------------------------------------------------------
`ifndef PRIME_COUNT_SIEVE_ASSERT_SVH
`define PRIME_COUNT_SIEVE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pcs_pkg.sv
// ---------------------------------------------------------------------------
// pcs_pkg
// widths, limits and sequencer states of the prime count sieve
// ---------------------------------------------------------------------------
package pcs_pkg;

  localparam int MAX_N   = 65536;
  localparam int LIMIT_W = 17;
  localparam int COUNT_W = 13;
  localparam int ADDR_W  = $clog2(MAX_N);
  // sieving index runs up to ceil(sqrt(MAX_N))
  localparam int ROOT_W  = (ADDR_W + 1) / 2 + 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_N);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_RDI  = 6'b000100,
    S_CHKI = 6'b001000,
    S_MARK = 6'b010000,
    S_CNT  = 6'b100000
  } pcs_state_t;

endpackage

FILE: rtl/prime_count_sieve.sv
// ---------------------------------------------------------------------------
// prime_count_sieve
// counts primes below a limit with a sieve over a one-bit map memory
// ---------------------------------------------------------------------------
// a limit <= 2 or above MAX_N gives its result in the cycle after the request;
// otherwise the map is filled, each i with i*i < n probed, multiples of each prime found
// cleared and the map counted; one map access per cycle on the single port sets the rate
// throughput: one request at a time, in_tready is low while the sieve runs
// reset: synchronous active-low rst_n clears the sequencer and output valid,
// the map memory is not cleared since every request rewrites what it reads
module prime_count_sieve (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pcs_pkg::IN_TDATA_W-1:0]   in_tdata,   // [16:0] limit
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pcs_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [12:0] prime_count
  output logic                             out_tuser   // [0] out_of_range
);
  import pcs_pkg::*;

  pcs_state_t           state_r, state_nxt;
  logic [LIMIT_W-1:0]   n_r, n_nxt;
  logic [LIMIT_W-1:0]   k_r, k_nxt;
  logic [LIMIT_W-1:0]   j_r, j_nxt;
  logic [LIMIT_W-1:0]   sq_r, sq_nxt;
  logic [ROOT_W-1:0]    i_r, i_nxt;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                 out_oor_r, out_oor_nxt;

  logic                 map_mem [MAX_N];
  logic                 rd_data_r;
  logic                 mem_we;
  logic                 mem_wd;
  logic [ADDR_W-1:0]    mem_addr;

  logic [LIMIT_W-1:0]   lim;
  logic                 accept;
  logic [LIMIT_W-1:0]   sq_step;

  assign lim       = in_tdata[LIMIT_W-1:0];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // (i+1)^2 = i^2 + 2i + 1
  assign sq_step = sq_r + {{(LIMIT_W-ROOT_W-1){1'b0}}, i_r, 1'b1};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-COUNT_W){1'b0}}, out_count_r};
  assign out_tuser  = out_oor_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    sq_nxt        = sq_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_count_nxt = out_count_r;
    out_oor_nxt   = out_oor_r;
    mem_we        = 1'b0;
    mem_wd        = 1'b0;
    mem_addr      = k_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (lim > MAX_LIMIT) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = '0;
            out_oor_nxt   = 1'b1;
          end else if (lim <= LIMIT_W'(2)) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = '0;
            out_oor_nxt   = 1'b0;
          end else begin
            n_nxt     = lim;
            k_nxt     = LIMIT_W'(2);
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (k_r < n_r) begin
          mem_we   = 1'b1;
          mem_wd   = 1'b1;
          mem_addr = k_r[ADDR_W-1:0];
          k_nxt    = k_r + LIMIT_W'(1);
        end else begin
          i_nxt     = ROOT_W'(2);
          sq_nxt    = LIMIT_W'(4);
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        mem_addr = {{(ADDR_W-ROOT_W){1'b0}}, i_r};
        if (sq_r >= n_r) begin
          k_nxt     = LIMIT_W'(2);
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_CNT;
        end else begin
          state_nxt = S_CHKI;
        end
      end
      S_CHKI: begin
        if (rd_data_r) begin
          j_nxt     = sq_r;
          state_nxt = S_MARK;
        end else begin
          i_nxt     = i_r + ROOT_W'(1);
          sq_nxt    = sq_step;
          state_nxt = S_RDI;
        end
      end
      S_MARK: begin
        if (j_r < n_r) begin
          mem_we   = 1'b1;
          mem_wd   = 1'b0;
          mem_addr = j_r[ADDR_W-1:0];
          j_nxt    = j_r + {{(LIMIT_W-ROOT_W){1'b0}}, i_r};
        end else begin
          i_nxt     = i_r + ROOT_W'(1);
          sq_nxt    = sq_step;
          state_nxt = S_RDI;
        end
      end
      S_CNT: begin
        // read data arrives in the cycle after its address
        if (pend_r && rd_data_r && (cnt_r != COUNT_MAX)) begin
          cnt_nxt = cnt_r + COUNT_W'(1);
        end
        if (k_r < n_r) begin
          mem_addr = k_r[ADDR_W-1:0];
          k_nxt    = k_r + LIMIT_W'(1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_r;
          out_oor_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    sq_r        <= sq_nxt;
    i_r         <= i_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  // single-port candidate map
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_addr] <= mem_wd;
    end
    rd_data_r <= map_mem[mem_addr];
  end

endmodule

FILE: rtl/pcs_checker.sv
// ---------------------------------------------------------------------------
// pcs_checker
// port-level checks of the prime count sieve, bound to the top level
// ---------------------------------------------------------------------------
`include "prime_count_sieve_assert.svh"

module pcs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [pcs_pkg::IN_TDATA_W-1:0]   in_tdata,   // [16:0] limit
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pcs_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [12:0] prime_count
  input logic                             out_tuser   // [0] out_of_range
);
  import pcs_pkg::*;

  logic [LIMIT_W-1:0] lim;
  logic               in_acc;
  logic               quick;
  logic               count_zero;

  assign lim        = in_tdata[LIMIT_W-1:0];
  assign in_acc     = in_tvalid && in_tready;
  assign quick      = (lim <= LIMIT_W'(2)) || (lim > MAX_LIMIT);
  assign count_zero = (out_tdata[COUNT_W-1:0] == '0);

  `PCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `PCS_ASSERT_NOW(a_oor_zero, clk, rst_n, out_tvalid && out_tuser, count_zero, "out of range result with nonzero count")
  `PCS_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_acc && !quick, !in_tready && !out_tvalid, "sieve request did not occupy the block")
  `PCS_ASSERT_NEXT(a_quick_result, clk, rst_n, in_acc && quick, out_tvalid && count_zero, "trivial request gave no zero result")

endmodule

bind prime_count_sieve pcs_checker u_pcs_checker (.*);

FILE: test/prime_count_sieve_checker.sv
// ----------------------------------------------------------------------------
// prime_count_sieve_checker
// watches both streams of the prime count sieve, runs its own sieve for each
// accepted request and compares every result against the oldest prediction
// ----------------------------------------------------------------------------
module prime_count_sieve_checker
  import pcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [16:0] limit
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,   // [12:0] prime_count
  input  logic                   out_tuser,   // [0] out_of_range
  output int                     errors,
  output int                     outstanding,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic [COUNT_W-1:0] count;
    logic               over_limit;
  } sieve_result_t;

  bit            sieve_map [MAX_N];
  sieve_result_t pending_counts [$];
  sieve_result_t want;
  int            err_cnt = 0;
  int            wait_cnt = 0;
  int            done_cnt = 0;

  assign errors      = err_cnt;
  assign outstanding = wait_cnt;
  assign checked     = done_cnt;

  task automatic report_error(input string msg);
    $display("%0t ns  sieve check: %s", $time, msg);
    err_cnt++;
  endtask

  // rewrites the map for every in-range limit above 2, as the block does
  function automatic sieve_result_t sieve_predict(input logic [LIMIT_W-1:0] limit);
    sieve_result_t res;
    int unsigned   n;
    int unsigned   i;
    int unsigned   j;
    int unsigned   tally;
    n              = 32'(limit);
    res.limit      = limit;
    res.count      = '0;
    res.over_limit = 1'b0;
    if (limit > MAX_LIMIT) begin
      res.over_limit = 1'b1;
    end else if (n > 2) begin
      sieve_map[0] = 1'b0;
      sieve_map[1] = 1'b0;
      for (i = 2; i < n; i++) sieve_map[i] = 1'b1;
      for (i = 2; i * i < n; i++) begin
        if (sieve_map[i]) begin
          for (j = i * i; j < n; j += i) sieve_map[j] = 1'b0;
        end
      end
      tally = 0;
      for (i = 2; i < n; i++) begin
        if (sieve_map[i]) tally++;
      end
      res.count = (tally > COUNT_MAX) ? COUNT_MAX : COUNT_W'(tally);
    end
    return res;
  endfunction

  // results are taken before new requests so a same-edge request never
  // satisfies an older result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        done_cnt++;
        if (pending_counts.size() == 0) begin
          report_error($sformatf("result count=%0d out_of_range=%b with no request waiting",
                                 out_tdata[COUNT_W-1:0], out_tuser));
        end else begin
          want = pending_counts.pop_front();
          if (out_tdata[COUNT_W-1:0] !== want.count)
            report_error($sformatf("limit %0d: prime_count %0d, expected %0d",
                                   want.limit, out_tdata[COUNT_W-1:0], want.count));
          if (out_tuser !== want.over_limit)
            report_error($sformatf("limit %0d: out_of_range %b, expected %b",
                                   want.limit, out_tuser, want.over_limit));
          if (out_tdata[OUT_TDATA_W-1:COUNT_W] !== '0)
            report_error($sformatf("limit %0d: tdata padding %b not zero",
                                   want.limit, out_tdata[OUT_TDATA_W-1:COUNT_W]));
        end
      end
      if (in_tvalid && in_tready)
        pending_counts.push_back(sieve_predict(in_tdata[LIMIT_W-1:0]));
      wait_cnt = pending_counts.size();
    end
  end

endmodule

FILE: test/prime_count_sieve_tb.sv
// ----------------------------------------------------------------------------
// prime_count_sieve_tb
// sends limits to the prime count sieve with random gaps and result stalls;
// a checker beside the block predicts and compares every count
// ----------------------------------------------------------------------------
module prime_count_sieve_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [16:0] limit
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [12:0] prime_count
  logic                   out_tuser;         // [0] out_of_range

  int errors;
  int outstanding;
  int checked;

  bit quiet       = 1'b0;
  int stall_left  = 0;
  int sent_cnt    = 0;
  int above_cnt   = 0;
  int largest_lim = 0;

  always #10 clk = ~clk;

  prime_count_sieve i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  prime_count_sieve_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // receiver stalls: mostly short, now and then long, none while quiet
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_limit(input logic [LIMIT_W-1:0] limit);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 55)  gap = 0;
    else if (pick < 90)      gap = $urandom_range(1, 3);
    else                     gap = $urandom_range(4, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(limit);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_cnt++;
    if (limit > MAX_LIMIT) above_cnt++;
    else if (int'(limit) > largest_lim) largest_lim = int'(limit);
  endtask

  // sender holds off until every request has its result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [LIMIT_W-1:0] random_limit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       return LIMIT_W'($urandom_range(0, 2));
    else if (pick < 65) return LIMIT_W'($urandom_range(3, 300));
    else if (pick < 85) return LIMIT_W'($urandom_range(301, 1500));
    else if (pick < 97) return LIMIT_W'($urandom_range(MAX_N + 1, 2 ** LIMIT_W - 1));
    else                return LIMIT_W'($urandom_range(1501, 6000));
  endfunction

  initial begin : stimulus
    int unsigned directed [] = '{0, 1, 2, 3, 4, 5, 9, 10, 11, 25, 26, 49, 50, 121, 122,
                                 1000, MAX_N, MAX_N + 1, 100000, 2 ** LIMIT_W - 1,
                                 3, 2, 65535 + 65536};
    int k;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[d]) send_limit(LIMIT_W'(directed[d]));
    drain_results();

    for (k = 0; k < 78; k++) begin
      quiet = (k >= 40 && k < 60);
      if (k == 50) drain_results();
      send_limit(random_limit());
    end
    quiet = 1'b0;
    drain_results();
    repeat (20) @(negedge clk);

    $display("covered %0d limits: %0d above MAX_N, largest sieved limit %0d",
             sent_cnt, above_cnt, largest_lim);
    $display("%0d results compared under random gaps, stalls and unthrottled stretches",
             checked);
    if (errors == 0)
      $display("prime_count_sieve_tb: PASS");
    else
      $display("prime_count_sieve_tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    #500ms;
    $display("prime_count_sieve_tb: FAIL");
    $finish;
  end

endmodule
